// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/swf_pkg.sv -----
// Shared types, constants and table generators for the wow/flutter delay.
package swf_pkg;

  // Shared multiply-accumulate datapath widths
  localparam int MUL_W = 21;
  localparam int ACC_W = 40;

  localparam logic [16:0] UNITY = 17'd65536;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_WOW_STEP   = 3'd1,
    REG_FLUT_STEP  = 3'd2,
    REG_WOW_DEPTH  = 3'd3,
    REG_FLUT_DEPTH = 3'd4,
    REG_SAT        = 3'd5,
    REG_WET        = 3'd6
  } cfg_reg_t;

  // Unsigned quotient by restoring shift and subtract, for table building
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    int b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine entry in Q15, built from a Taylor series in Q30
  function automatic logic [15:0] sine_entry(input logic [63:0] k, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * HALF_PI_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - udiv64(x2, 64'd72);
    t  = Q30_ONE - udiv64((x2 * t) >> 30, 64'd42);
    t  = Q30_ONE - udiv64((x2 * t) >> 30, 64'd20);
    t  = Q30_ONE - udiv64((x2 * t) >> 30, 64'd6);
    s  = (((x * t) >> 30) + 64'd16384) >> 15;
    return (s > 64'd32767) ? 16'd32767 : s[15:0];
  endfunction

  // tanh(8k/N) in Q15 from an exp series and repeated squaring
  function automatic logic [15:0] tanh_entry(input logic [63:0] k, input int tbits);
    logic [63:0] v;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] t;
    int i;
    v = (k << (34 - tbits)) >> 5;
    e = Q30_ONE - udiv64((v * Q30_ONE) >> 30, 64'd6);
    e = Q30_ONE - udiv64((v * e) >> 30, 64'd5);
    e = Q30_ONE - (((v * e) >> 30) >> 2);
    e = Q30_ONE - udiv64((v * e) >> 30, 64'd3);
    e = Q30_ONE - (((v * e) >> 30) >> 1);
    e = Q30_ONE - ((v * e) >> 30);
    for (i = 0; i < 5; i++) begin
      e = (e * e) >> 30;
    end
    den = Q30_ONE + e;
    num = (Q30_ONE - e) * 64'd32768;
    t = udiv64(num + (den >> 1), den);
    return (t > 64'd32767) ? 16'd32767 : t[15:0];
  endfunction

endpackage

// ----- rtl/swf_mac.sv -----
// Shared signed multiply-accumulate unit used by every multiply-accumulate step.
module swf_mac (
  input  logic                                   clk,
  input  swf_pkg::mac_ctl_t                      ctl,
  input  logic signed [swf_pkg::ACC_W-1:0]       init,
  input  logic signed [swf_pkg::MUL_W-1:0]       a,
  input  logic signed [swf_pkg::MUL_W-1:0]       b,
  output logic signed [swf_pkg::ACC_W-1:0]       acc
);

  logic signed [2*swf_pkg::MUL_W-1:0] prod;
  logic signed [swf_pkg::ACC_W-1:0]   base;

  assign prod = a * b;
  assign base = ctl.clr ? init : acc;

  // Load or accumulate one product per step
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + $signed(prod[swf_pkg::ACC_W-1:0]);
    end
  end

endmodule

// ----- rtl/swf_store.sv -----
// Stereo circular delay stores with write index and fill tracking.
module swf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic signed [15:0]   wr_left,
  input  logic signed [15:0]   wr_right,
  input  logic                 adv,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [15:0]   rd_left,
  output logic signed [15:0]   rd_right,
  output logic [AW-1:0]        wr_index
);

  logic signed [15:0] left_mem [DEPTH];
  logic signed [15:0] right_mem [DEPTH];
  logic signed [15:0] left_q;
  logic signed [15:0] right_q;
  logic               rd_ok;
  logic               wrapped;

  // Advance the write index; note the first wrap so the whole store is live
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index <= '0;
      wrapped  <= 1'b0;
    end else if (adv) begin
      if (wr_index == AW'(DEPTH - 1)) begin
        wr_index <= '0;
        wrapped  <= 1'b1;
      end else begin
        wr_index <= wr_index + AW'(1);
      end
    end
  end

  // Write both channels at the current index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_index]  <= wr_left;
      right_mem[wr_index] <= wr_right;
    end
  end

  // Registered read; entries not yet written read as zero
  always_ff @(posedge clk) begin
    left_q  <= left_mem[rd_addr];
    right_q <= right_mem[rd_addr];
    rd_ok   <= wrapped || (rd_addr <= wr_index);
  end

  assign rd_left  = rd_ok ? left_q : 16'sd0;
  assign rd_right = rd_ok ? right_q : 16'sd0;

endmodule

// ----- rtl/swf_tables.sv -----
// Quarter-wave sine ROM and tanh ROM with registered reads.
module swf_tables #(
  parameter int SB = 10,
  parameter int TB = 10
) (
  input  logic            clk,
  input  logic [SB-2:0]   sine_addr,
  output logic [15:0]     sine_data,
  input  logic [TB:0]     tanh_addr,
  output logic [15:0]     tanh_data
);

  localparam int QB = SB - 2;
  localparam int QN = 1 << QB;
  localparam int TN = 1 << TB;

  logic [15:0] sine_rom [QN+1];
  logic [15:0] tanh_rom [TN+1];

  // Quarter wave, both ends included
  for (genvar g = 0; g <= QN; g++) begin : g_sine
    localparam logic [15:0] ENTRY = swf_pkg::sine_entry(64'(g), QB);
    assign sine_rom[g] = ENTRY;
  end

  // Curve entries, then full scale past the end
  for (genvar g = 0; g < TN; g++) begin : g_tanh
    localparam logic [15:0] ENTRY = swf_pkg::tanh_entry(64'(g), TB);
    assign tanh_rom[g] = ENTRY;
  end
  assign tanh_rom[TN] = 16'd32767;

  always_ff @(posedge clk) begin
    sine_data <= sine_rom[sine_addr];
    tanh_data <= tanh_rom[tanh_addr];
  end

endmodule

// ----- rtl/stereo_wow_flutter_delay_top.sv -----
// Top level of the stereo wow/flutter modulated delay.
//
// Input stream: s_tdata carries one stereo frame, s_tlast marks the last frame
// of a buffer. Output stream: m_tdata/m_tlast carry the processed frame.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per transfer;
// cfg_ready is always high. Write registers only while the block is idle.
// One frame at a time: s_tready is high only while idle. For an enabled
// frame a small sequencer runs both sine lookups, the delay, the two store
// reads and eleven steps per channel, eight of them multiply-accumulate,
// through one shared multiplier, then raises output valid.
// A disabled frame goes straight to the output step and changes no state.
// The output register holds a result until the sink takes it; a new input
// is accepted meanwhile, and its result waits until the register frees up.
// Reset clears registers, phases and write index at once; the stores need
// no clearing pass, since entries not yet written since reset read as zero.
module stereo_wow_flutter_delay_top #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SINE_TABLE_BITS = 10,
  parameter int TANH_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_in[15:0], right_in[31:16]
  input  logic        s_tlast,   // frame_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_out[15:0], right_out[31:16]
  output logic        m_tlast,   // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int QB    = SINE_TABLE_BITS - 2;
  localparam int TB    = TANH_TABLE_BITS;
  localparam int FB    = 18 - TANH_TABLE_BITS;
  localparam int DLW   = AW + 8;
  localparam int RPW   = AW + 9;
  localparam int MUL_W = swf_pkg::MUL_W;
  localparam int ACC_W = swf_pkg::ACC_W;
  localparam logic [RPW-1:0] SPAN = RPW'(DELAY_DEPTH * 256);
  localparam logic signed [25:0] DLY_HI = 26'(( DELAY_DEPTH - 2) * 256);
  localparam logic signed [25:0] DLY_LO = 26'sd256;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_SIN0 = 21'h000002,
    S_SIN1 = 21'h000004,
    S_SIN2 = 21'h000008,
    S_DLY  = 21'h000010,
    S_POS  = 21'h000020,
    S_RD0  = 21'h000040,
    S_RD1  = 21'h000080,
    S_RD2  = 21'h000100,
    S_INT0 = 21'h000200,
    S_INT1 = 21'h000400,
    S_DRV  = 21'h000800,
    S_TH0  = 21'h001000,
    S_TH1  = 21'h002000,
    S_TH2  = 21'h004000,
    S_BL0  = 21'h008000,
    S_BL1  = 21'h010000,
    S_MX0  = 21'h020000,
    S_MX1  = 21'h040000,
    S_MX2  = 21'h080000,
    S_OUT  = 21'h100000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic        effect_enable;
  logic [31:0] wow_phase_step;
  logic [31:0] flutter_phase_step;
  logic [19:0] wow_depth;
  logic [19:0] flutter_depth;
  logic [16:0] saturation_amount;
  logic [16:0] wet_mix;

  // Oscillator state and channel select
  logic [31:0] wow_phase;
  logic [31:0] flutter_phase;
  logic        ch;

  // Frame payload and intermediate results
  logic signed [15:0] dry_l;
  logic signed [15:0] dry_r;
  logic               last_q;
  logic signed [15:0] res_l;
  logic signed [15:0] res_r;
  logic [DLW-1:0]     delay_q;
  logic [AW-1:0]      i0_q;
  logic [7:0]         f_q;
  logic signed [15:0] l0;
  logic signed [15:0] r0;
  logic signed [15:0] l1;
  logic signed [15:0] r1;
  logic signed [16:0] x_q;
  logic [TB-1:0]      tidx;
  logic [FB-1:0]      fr_q;
  logic               ovf_q;
  logic [15:0]        t0_q;
  logic signed [16:0] ts_q;
  logic signed [16:0] y_q;

  // Shared unit, stores and tables
  swf_pkg::mac_ctl_t        mac_ctl;
  logic signed [ACC_W-1:0]  mac_init;
  logic signed [MUL_W-1:0]  mac_a;
  logic signed [MUL_W-1:0]  mac_b;
  logic signed [ACC_W-1:0]  acc;
  logic [AW-1:0]            rd_addr;
  logic signed [15:0]       rd_left;
  logic signed [15:0]       rd_right;
  logic [AW-1:0]            wr_index;
  logic                     st_wr;
  logic                     st_adv;
  logic [QB:0]              sine_addr;
  logic [15:0]              sine_data;
  logic [TB:0]              tanh_addr;
  logic [15:0]              tanh_data;

  // Derived values
  logic               in_xfer;
  logic               out_free;
  logic [QB:0]        wow_k;
  logic [QB:0]        flut_k;
  logic signed [16:0] sine_mag;
  logic signed [16:0] wow_sine;
  logic signed [16:0] flut_sine;
  logic signed [25:0] dsum;
  logic [RPW-1:0]     rp_raw;
  logic [RPW-1:0]     rp;
  logic [AW-1:0]      i1;
  logic signed [15:0] s0;
  logic signed [15:0] s1;
  logic signed [15:0] dry;
  logic signed [16:0] x_c;
  logic signed [16:0] mag;
  logic [19:0]        drive;
  logic signed [16:0] tdiff;
  logic [15:0]        tmag;
  logic signed [16:0] tm17;
  logic signed [23:0] mix;
  logic signed [15:0] mix_sat;
  logic [16:0]        cfg_v17;
  logic [16:0]        cfg_clip;

  assign in_xfer   = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  swf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .init (mac_init),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  swf_store #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (st_wr),
    .wr_left  (dry_l),
    .wr_right (dry_r),
    .adv      (st_adv),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .wr_index (wr_index)
  );

  swf_tables #(
    .SB (SINE_TABLE_BITS),
    .TB (TANH_TABLE_BITS)
  ) u_tables (
    .clk       (clk),
    .sine_addr (sine_addr),
    .sine_data (sine_data),
    .tanh_addr (tanh_addr),
    .tanh_data (tanh_data)
  );

  // Fold each phase into a quarter-wave table address
  assign wow_k  = wow_phase[30] ? ((QB+1)'(1 << QB) - {1'b0, wow_phase[29 -: QB]})
                                : {1'b0, wow_phase[29 -: QB]};
  assign flut_k = flutter_phase[30]
                ? ((QB+1)'(1 << QB) - {1'b0, flutter_phase[29 -: QB]})
                : {1'b0, flutter_phase[29 -: QB]};
  assign sine_mag  = $signed({1'b0, sine_data});
  assign wow_sine  = wow_phase[31] ? -sine_mag : sine_mag;
  assign flut_sine = flutter_phase[31] ? -sine_mag : sine_mag;

  // Delay in Q.8 before clamping
  assign dsum = 26'($signed(acc[ACC_W-1:15])) + 26'(wow_depth[19:1]);

  // Read position behind the write index, wrapped into the store span
  assign rp_raw = {1'b0, wr_index, 8'd0} + SPAN - RPW'(delay_q);
  assign rp     = (rp_raw >= SPAN) ? (rp_raw - SPAN) : rp_raw;
  assign i1     = (i0_q == AW'(DELAY_DEPTH - 1)) ? '0 : (i0_q + AW'(1));

  // Channel operands
  assign s0  = ch ? r0 : l0;
  assign s1  = ch ? r1 : l1;
  assign dry = ch ? dry_r : dry_l;

  // Soft-saturation operands
  assign x_c   = $signed(acc[24:8]);
  assign mag   = x_c[16] ? -x_c : x_c;
  assign drive = 20'(swf_pkg::UNITY) + 20'({saturation_amount, 2'b00});
  assign tdiff = $signed({1'b0, tanh_data}) - $signed({1'b0, t0_q});
  assign tmag  = ovf_q ? 16'd32767 : (t0_q + acc[FB +: 16]);
  assign tm17  = $signed({1'b0, tmag});

  // Output mix, saturated to 16 bits
  assign mix     = $signed(acc[ACC_W-1:16]);
  assign mix_sat = (mix > 24'sd32767)  ? 16'sh7FFF :
                   (mix < -24'sd32768) ? 16'sh8000 : mix[15:0];

  // Config write value, masked and limited to unity
  assign cfg_v17  = cfg_data[16:0];
  assign cfg_clip = (cfg_v17 > swf_pkg::UNITY) ? swf_pkg::UNITY : cfg_v17;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_enable      <= 1'b0;
      wow_phase_step     <= '0;
      flutter_phase_step <= '0;
      wow_depth          <= '0;
      flutter_depth      <= '0;
      saturation_amount  <= '0;
      wet_mix            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (swf_pkg::cfg_reg_t'(cfg_index))
        swf_pkg::REG_ENABLE:     effect_enable      <= cfg_data[0];
        swf_pkg::REG_WOW_STEP:   wow_phase_step     <= cfg_data;
        swf_pkg::REG_FLUT_STEP:  flutter_phase_step <= cfg_data;
        swf_pkg::REG_WOW_DEPTH:  wow_depth          <= cfg_data[19:0];
        swf_pkg::REG_FLUT_DEPTH: flutter_depth      <= cfg_data[19:0];
        swf_pkg::REG_SAT:        saturation_amount  <= cfg_clip;
        swf_pkg::REG_WET:        wet_mix            <= cfg_clip;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = effect_enable ? S_SIN0 : S_OUT;
        end
      end
      S_SIN0: state_next = S_SIN1;
      S_SIN1: state_next = S_SIN2;
      S_SIN2: state_next = S_DLY;
      S_DLY:  state_next = S_POS;
      S_POS:  state_next = S_RD0;
      S_RD0:  state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_INT0;
      S_INT0: state_next = S_INT1;
      S_INT1: state_next = S_DRV;
      S_DRV:  state_next = S_TH0;
      S_TH0:  state_next = S_TH1;
      S_TH1:  state_next = S_TH2;
      S_TH2:  state_next = S_BL0;
      S_BL0:  state_next = S_BL1;
      S_BL1:  state_next = S_MX0;
      S_MX0:  state_next = S_MX1;
      S_MX1:  state_next = S_MX2;
      S_MX2:  state_next = ch ? S_OUT : S_INT0;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Operand selection for the shared unit, tables and store
  always_comb begin
    mac_ctl   = '0;
    mac_init  = '0;
    mac_a     = '0;
    mac_b     = '0;
    sine_addr = wow_k;
    tanh_addr = {1'b0, acc[33 -: TB]};
    rd_addr   = i0_q;
    st_wr     = (state == S_SIN0);
    st_adv    = (state == S_MX2) && ch;
    case (state)
      S_SIN1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1};
        mac_a     = MUL_W'(wow_depth);
        mac_b     = MUL_W'(wow_sine);
        sine_addr = flut_k;
      end
      S_SIN2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_W'(flutter_depth);
        mac_b   = MUL_W'(flut_sine);
      end
      S_RD1: rd_addr = i1;
      S_INT0: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b1};
        mac_init = ACC_W'(128);
        mac_a    = MUL_W'(s0);
        mac_b    = MUL_W'(9'd256 - {1'b0, f_q});
      end
      S_INT1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_W'(s1);
        mac_b   = MUL_W'(f_q);
      end
      S_DRV: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_W'(mag);
        mac_b   = MUL_W'(drive);
      end
      S_TH1: tanh_addr = {1'b0, tidx} + (TB+1)'(1);
      S_TH2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_W'(tdiff);
        mac_b   = MUL_W'(fr_q);
      end
      S_BL0: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b1};
        mac_init = ACC_W'(32768);
        mac_a    = MUL_W'(x_q);
        mac_b    = MUL_W'(swf_pkg::UNITY - saturation_amount);
      end
      S_BL1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_W'(ts_q);
        mac_b   = MUL_W'(saturation_amount);
      end
      S_MX0: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b1};
        mac_init = ACC_W'(32768);
        mac_a    = MUL_W'(dry);
        mac_b    = MUL_W'(swf_pkg::UNITY - wet_mix);
      end
      S_MX1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_W'(y_q);
        mac_b   = MUL_W'(wet_mix);
      end
      default: ;
    endcase
  end

  // Control state: sequencer, channel, oscillators, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ch            <= 1'b0;
      wow_phase     <= '0;
      flutter_phase <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MX2) begin
        ch <= !ch;
        if (ch) begin
          wow_phase     <= wow_phase + wow_phase_step;
          flutter_phase <= flutter_phase + flutter_phase_step;
        end
      end
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          dry_l  <= $signed(s_tdata[15:0]);
          dry_r  <= $signed(s_tdata[31:16]);
          res_l  <= $signed(s_tdata[15:0]);
          res_r  <= $signed(s_tdata[31:16]);
          last_q <= s_tlast;
        end
      end
      S_DLY: begin
        if (dsum > DLY_HI) begin
          delay_q <= DLW'(DLY_HI);
        end else if (dsum < DLY_LO) begin
          delay_q <= DLW'(DLY_LO);
        end else begin
          delay_q <= dsum[DLW-1:0];
        end
      end
      S_POS: begin
        i0_q <= rp[AW+7:8];
        f_q  <= rp[7:0];
      end
      S_RD1: begin
        l0 <= rd_left;
        r0 <= rd_right;
      end
      S_RD2: begin
        l1 <= rd_left;
        r1 <= rd_right;
      end
      S_DRV: x_q <= x_c;
      S_TH0: begin
        tidx  <= acc[33 -: TB];
        fr_q  <= acc[16 +: FB];
        ovf_q <= |acc[ACC_W-1:34];
      end
      S_TH1: t0_q <= tanh_data;
      S_BL0: ts_q <= x_q[16] ? -tm17 : tm17;
      S_MX0: y_q <= $signed(acc[32:16]);
      S_MX2: begin
        if (ch) begin
          res_r <= mix_sat;
        end else begin
          res_l <= mix_sat;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {res_r, res_l};
          m_tlast <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/swf_checker.sv -----
// Port-level checker for the wow/flutter delay, bound to the top level.
`include "assert_macros.svh"

module swf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // No result is shown right after reset
  `SWF_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

  // One frame at a time: busy right after an input transfer
  `SWF_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

  // No result appears in the cycle right after an input transfer made with no result shown
  `SWF_ASSERT(a_no_early, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "early result")

  // A stalled result holds its payload
  `SWF_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tlast}), "stall")

endmodule

bind stereo_wow_flutter_delay_top swf_checker u_swf_checker (.*);

// ----- tb/sv/stereo_wow_flutter_delay_checker.sv -----
// Stream monitor, frame predictor and result comparator for the wow/flutter delay.
module stereo_wow_flutter_delay_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          frames_pending,
  output int          frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4096;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } frame_t;

  frame_t expected_frames[$];

  // Shadow of the block's state and registers
  shortint     left_hist[DEPTH];
  shortint     right_hist[DEPTH];
  logic [11:0] wr_ptr;
  logic [31:0] wow_acc;
  logic [31:0] flut_acc;
  logic        fx_on;
  logic [31:0] wow_inc;
  logic [31:0] flut_inc;
  logic [19:0] wow_amt;
  logic [19:0] flut_amt;
  logic [16:0] sat_amt;
  logic [16:0] wet_amt;

  int sine_rom[1024];
  int tanh_rom[1024];

  // Quarter-wave sine in Q15 from a Taylor series in Q30
  function automatic int quarter_wave(logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * QUARTER_TURN_Q30) >> 8;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (((x * t) >> 30) + 64'd16384) >> 15;
    return (s > 64'd32767) ? 32767 : int'(s);
  endfunction

  // tanh(8k/1024) in Q15 through exp(-2x) and repeated squaring
  function automatic int tanh_point(logic [63:0] k);
    logic [63:0] v;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] t;
    v = (k << 24) >> 5;
    e = ONE_Q30 - ((v * ONE_Q30) >> 30) / 64'd6;
    e = ONE_Q30 - ((v * e) >> 30) / 64'd5;
    e = ONE_Q30 - ((v * e) >> 30) / 64'd4;
    e = ONE_Q30 - ((v * e) >> 30) / 64'd3;
    e = ONE_Q30 - ((v * e) >> 30) / 64'd2;
    e = ONE_Q30 - ((v * e) >> 30);
    for (int i = 0; i < 5; i++) e = (e * e) >> 30;
    den = ONE_Q30 + e;
    num = (ONE_Q30 - e) * 64'd32768;
    t = (num + den / 64'd2) / den;
    return (t > 64'd32767) ? 32767 : int'(t);
  endfunction

  // Interpolated tanh of a Q15 magnitude, flat beyond the table
  function automatic longint tanh_of(longint a);
    longint idx;
    longint fr;
    longint t0;
    longint t1;
    if (a >= 64'sd262144) return 32767;
    idx = a >>> 8;
    fr  = a & 255;
    t0  = tanh_rom[idx];
    t1  = (idx + 1 < 1024) ? tanh_rom[idx + 1] : 32767;
    return t0 + (((t1 - t0) * fr) >>> 8);
  endfunction

  // Fractional read behind the write pointer
  function automatic longint tap(ref shortint hist[DEPTH], input longint dly);
    longint span;
    longint rp;
    longint i0;
    longint fr;
    span = DEPTH * 256;
    rp = longint'(wr_ptr) * 256 + span - dly;
    if (rp >= span) rp -= span;
    i0 = rp >>> 8;
    fr = rp & 255;
    return (longint'(hist[i0]) * (256 - fr) + longint'(hist[(i0 + 1) % DEPTH]) * fr + 128)
           >>> 8;
  endfunction

  // Soft clip blended with the clean signal
  function automatic longint soft_clip(longint x);
    longint s;
    longint mag;
    longint t;
    s   = sat_amt;
    mag = (x < 0) ? -x : x;
    t   = tanh_of((mag * (65536 + 4 * s)) >>> 16);
    if (x < 0) t = -t;
    return (x * (65536 - s) + t * s + 32768) >>> 16;
  endfunction

  // Write, read back, shape and mix one channel
  function automatic logic [15:0] wet_channel(ref shortint hist[DEPTH], input longint dry,
                                              input longint dly);
    longint y;
    longint m;
    longint mix;
    hist[wr_ptr] = shortint'(dry);
    y   = soft_clip(tap(hist, dly));
    m   = wet_amt;
    mix = (dry * (65536 - m) + y * m + 32768) >>> 16;
    if (mix > 32767) mix = 32767;
    if (mix < -32768) mix = -32768;
    return mix[15:0];
  endfunction

  // Work out the output frame of one input frame and advance the shadow state
  function automatic frame_t process_frame(logic [31:0] data, logic last);
    frame_t f;
    longint sum;
    longint dly;
    f.left  = data[15:0];
    f.right = data[31:16];
    f.last  = last;
    if (fx_on) begin
      sum = longint'(wow_amt) * sine_rom[wow_acc[31:22]]
          + longint'(flut_amt) * sine_rom[flut_acc[31:22]];
      dly = (sum >>> 15) + longint'(wow_amt >> 1);
      if (dly > (DEPTH - 2) * 256) dly = (DEPTH - 2) * 256;
      if (dly < 256) dly = 256;
      f.left   = wet_channel(left_hist, longint'($signed(data[15:0])), dly);
      f.right  = wet_channel(right_hist, longint'($signed(data[31:16])), dly);
      wr_ptr   = wr_ptr + 12'd1;
      wow_acc  = wow_acc + wow_inc;
      flut_acc = flut_acc + flut_inc;
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s of frame %0d: got %h, expected %h",
             $realtime, what, frames_checked, got, want);
    fail_count++;
  endtask

  initial begin
    logic [63:0] k;
    for (int i = 0; i < 1024; i++) begin
      k = (i[8]) ? 64'd256 - (i & 255) : (i & 255);
      sine_rom[i] = i[9] ? -quarter_wave(k) : quarter_wave(k);
      tanh_rom[i] = tanh_point(i);
    end
    fail_count = 0;
    frames_checked = 0;
    frames_pending = 0;
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      foreach (left_hist[i]) begin
        left_hist[i]  = 0;
        right_hist[i] = 0;
      end
      wr_ptr = '0;
      wow_acc = '0;
      flut_acc = '0;
      fx_on = 1'b0;
      wow_inc = '0;
      flut_inc = '0;
      wow_amt = '0;
      flut_amt = '0;
      sat_amt = '0;
      wet_amt = '0;
      expected_frames.delete();
    end else begin
      // Mirror register writes
      if (cfg_valid && cfg_ready) begin
        case (swf_pkg::cfg_reg_t'(cfg_index))
          swf_pkg::REG_ENABLE:     fx_on    = cfg_data[0];
          swf_pkg::REG_WOW_STEP:   wow_inc  = cfg_data;
          swf_pkg::REG_FLUT_STEP:  flut_inc = cfg_data;
          swf_pkg::REG_WOW_DEPTH:  wow_amt  = cfg_data[19:0];
          swf_pkg::REG_FLUT_DEPTH: flut_amt = cfg_data[19:0];
          swf_pkg::REG_SAT:
            sat_amt = (cfg_data[16:0] > swf_pkg::UNITY) ? swf_pkg::UNITY : cfg_data[16:0];
          swf_pkg::REG_WET:
            wet_amt = (cfg_data[16:0] > swf_pkg::UNITY) ? swf_pkg::UNITY : cfg_data[16:0];
          default: ;
        endcase
      end
      // Compare each output transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          $display("[%0t] output transfer with no frame outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          if (m_tdata[15:0] !== want.left) report_mismatch("left", m_tdata[15:0], want.left);
          if (m_tdata[31:16] !== want.right)
            report_mismatch("right", m_tdata[31:16], want.right);
          if (m_tlast !== want.last) report_mismatch("last", {15'd0, m_tlast}, {15'd0, want.last});
        end
        frames_checked++;
      end
      // Predict each input transfer
      if (s_tvalid && s_tready) expected_frames.push_back(process_frame(s_tdata, s_tlast));
    end
    frames_pending = expected_frames.size();
  end

endmodule

// ----- tb/sv/stereo_wow_flutter_delay_top_tb.sv -----
// Stimulus, flow control and verdict for the wow/flutter delay.
module stereo_wow_flutter_delay_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = swf_pkg::REG_ENABLE;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int frames_pending;
  int frames_checked;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int cycle_count = 0;
  int frames_sent = 0;
  int reg_writes = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  stereo_wow_flutter_delay_top dut (.*);

  stereo_wow_flutter_delay_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Write one register, then drop cfg_valid before returning
  task automatic write_reg(swf_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // Offer one frame and hold it until the transfer; valid then stays high unless a random idle drops it
  task automatic send_frame(logic [15:0] l, logic [15:0] r, logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    frames_sent++;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // Drop valid and wait until every expected frame is back
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(int mode);
    case (mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
      default: begin src_idle_pct = 30; snk_stall_pct = 30; end
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass-through while disabled, extremes of the samples
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b1);
    drain();

    // Full depths give a long delay; oversized blend and mix
    write_reg(swf_pkg::REG_WOW_STEP, 32'h0100_0000);
    write_reg(swf_pkg::REG_FLUT_STEP, 32'hFFFF_FFFF);
    write_reg(swf_pkg::REG_WOW_DEPTH, 32'h000F_FFFF);
    write_reg(swf_pkg::REG_FLUT_DEPTH, 32'h000F_FFFF);
    write_reg(swf_pkg::REG_SAT, 32'h0001_FFFF);
    write_reg(swf_pkg::REG_WET, 32'h0001_FFFF);
    write_reg(swf_pkg::REG_ENABLE, 32'd1);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h0001, 16'hFFFF, 1'b1);
    drain();

    // Zero depths: the delay sits at its lower clamp of one sample
    write_reg(swf_pkg::REG_WOW_DEPTH, 32'd0);
    write_reg(swf_pkg::REG_FLUT_DEPTH, 32'd0);
    write_reg(swf_pkg::REG_SAT, 32'd0);
    write_reg(swf_pkg::REG_WET, 32'd65536);
    for (int i = 0; i < 4; i++) send_frame(rand_sample(), rand_sample(), i[0]);
    drain();

    // Half blend, dry mix, then a frozen stretch while disabled
    write_reg(swf_pkg::REG_SAT, 32'd32768);
    write_reg(swf_pkg::REG_WET, 32'd0);
    send_frame(16'h4000, 16'hC000, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    drain();
    write_reg(swf_pkg::REG_ENABLE, 32'd0);
    send_frame(16'h1234, 16'hEDCB, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    drain();
    write_reg(swf_pkg::REG_ENABLE, 32'd1);
    write_reg(swf_pkg::REG_WET, 32'd65536);
    send_frame(16'h2000, 16'hE000, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    drain();

    // Random settings under each flow-control pattern
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph % 4);
      write_reg(swf_pkg::REG_ENABLE, {31'd0, ph != 4});
      write_reg(swf_pkg::REG_WOW_STEP, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
      write_reg(swf_pkg::REG_FLUT_STEP, $urandom_range(1) ? $urandom : $urandom_range(1 << 25));
      write_reg(swf_pkg::REG_WOW_DEPTH, (ph == 5) ? 32'h000F_FFFF : $urandom_range(60000));
      write_reg(swf_pkg::REG_FLUT_DEPTH, (ph == 3) ? $urandom : $urandom_range(30000));
      write_reg(swf_pkg::REG_SAT, $urandom_range(131071));
      write_reg(swf_pkg::REG_WET, $urandom_range(131071));
      for (int i = 0; i < 64; i++) begin
        // Long sink hold-off while frames keep coming
        if (ph == 1 && i == 8) begin
          s_tvalid <= 1'b0;
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        send_frame(rand_sample(), rand_sample(), 1'($urandom));
      end
      drain();
    end

    $display("Sent %0d frames and %0d register writes; checked %0d output frames",
             frames_sent, reg_writes, frames_checked);
    $display("Covered pass-through, delay clamps, blend and mix extremes, stalls and hold-off");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
